[src/csr_sparse_matvec_top_defines.svh]
// Assertion macros for the sparse matvec block.
// Both expect clk in scope; CSM_ASSERT also expects arst_n.
`ifndef CSR_SPARSE_MATVEC_TOP_DEFINES_SVH
`define CSR_SPARSE_MATVEC_TOP_DEFINES_SVH

`ifndef SYNTH
`define CSM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("csm assertion failed");
`define CSM_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("csm assertion failed");
`else
`define CSM_ASSERT(lbl, prop)
`define CSM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[src/csm_pkg.sv]
`default_nettype none
package csm_pkg;

	localparam int VECTOR_DEPTH = 4096;
	localparam int VEC_AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

	localparam int QUEUE_DEPTH = 4;	// power of two
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_NZ    = 2'd1;
	localparam logic [1:0] CMD_CLOSE = 2'd2;

	localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

	typedef logic [VEC_AW-1:0] vec_addr_t;
	typedef logic [QUEUE_AW-1:0] queue_ptr_t;
	typedef logic [QUEUE_CW-1:0] queue_cnt_t;

	// one queued accumulate step; emit closes the row after adding prod
	typedef struct packed {
		logic signed [31:0] prod;
		logic               emit;
	} queue_entry_t;

endpackage
`default_nettype wire

[src/csm_front.sv]
`default_nettype none
module csm_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            cmd,
	input  wire logic [11:0]           index,
	input  wire logic signed [15:0]    value,
	input  wire logic                  row_last,
	output logic                       push,
	output csm_pkg::queue_entry_t      push_entry,
	input  wire logic                  q_full
);

	logic [15:0] vec_mem [csm_pkg::VECTOR_DEPTH];

	logic                accept;
	logic                in_range;
	csm_pkg::vec_addr_t  addr;

	logic                valid_s1;
	logic                nz_s1;
	logic                last_s1;
	logic                inr_s1;
	logic signed [15:0]  val_s1;
	logic signed [15:0]  vec_s1;
	logic signed [15:0]  vec_eff;
	logic signed [31:0]  prod;

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign in_range = (32'(index) < csm_pkg::VECTOR_DEPTH);
	assign addr     = csm_pkg::vec_addr_t'(index);

	// vector store: write for cmd 0, read for a nonzero; data lands with the item in s1
	always_ff @(posedge clk) begin
		if (accept && cmd == csm_pkg::CMD_WRITE && in_range) begin
			vec_mem[addr] <= value;
		end
		if (accept && cmd == csm_pkg::CMD_NZ) begin
			vec_s1 <= vec_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (cmd == csm_pkg::CMD_NZ) || (cmd == csm_pkg::CMD_CLOSE);
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nz_s1   <= (cmd == csm_pkg::CMD_NZ);
			last_s1 <= row_last;
			inr_s1  <= in_range;
			val_s1  <= value;
		end
	end

	assign push    = valid_s1 && !q_full;
	assign vec_eff = inr_s1 ? vec_s1 : 16'sd0;
	assign prod    = val_s1 * vec_eff;

	always_comb begin
		push_entry.prod = nz_s1 ? prod : 32'sd0;
		push_entry.emit = !nz_s1 || last_s1;
	end

endmodule
`default_nettype wire

[src/csm_queue.sv]
`default_nettype none
`include "csr_sparse_matvec_top_defines.svh"
module csm_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire csm_pkg::queue_entry_t push_entry,
	output logic                       full,
	output logic                       q_valid,
	output csm_pkg::queue_entry_t      head,
	input  wire logic                  pop
);

	csm_pkg::queue_entry_t entries [csm_pkg::QUEUE_DEPTH];
	csm_pkg::queue_ptr_t   wr_ptr_q;
	csm_pkg::queue_ptr_t   rd_ptr_q;
	csm_pkg::queue_cnt_t   count_q;

	assign full    = (count_q == csm_pkg::QUEUE_CW'(csm_pkg::QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = entries[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`CSM_ASSERT(a_no_push_full, !(push && full))
	`CSM_ASSERT(a_no_pop_empty, !(pop && !q_valid))
	`CSM_ASSERT(a_cnt_up, (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
	`CSM_ASSERT(a_cnt_down, (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
	`CSM_ASSERT(a_cnt_bound, count_q <= csm_pkg::QUEUE_CW'(csm_pkg::QUEUE_DEPTH))

endmodule
`default_nettype wire

[src/csm_back.sv]
`default_nettype none
module csm_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire csm_pkg::queue_entry_t head,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [47:0]         row_sum,
	output logic [19:0]                row_number,
	output logic                       saturated
);

	logic signed [47:0] acc_q;
	logic               sat_q;
	logic [19:0]        row_q;
	logic               out_valid_q;

	logic signed [48:0] sum;
	logic               ovf;
	logic signed [47:0] clamped;
	logic               out_free;

	assign out_free = !out_valid_q || !out_stall;
	// a step that only accumulates can pass a stalled output
	assign pop      = q_valid && (!head.emit || out_free);

	assign sum     = {acc_q[47], acc_q} + {{17{head.prod[31]}}, head.prod};
	assign ovf     = (sum[48] != sum[47]);
	assign clamped = ovf ? (sum[48] ? csm_pkg::ACC_MIN : csm_pkg::ACC_MAX) : sum[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			sat_q       <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.emit) begin
				acc_q       <= '0;
				sat_q       <= 1'b0;
				row_q       <= row_q + 1'b1;
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					acc_q <= clamped;
					sat_q <= sat_q || ovf;
				end
				if (!out_stall) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.emit) begin
			row_sum    <= clamped;
			row_number <= row_q;
			saturated  <= sat_q || ovf;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[src/csr_sparse_matvec_top.sv]
// Sparse matrix times dense vector, rows streamed in compressed-row form.
// Input channel (in_valid/in_stall): cmd 0 writes value into vector entry
// index; cmd 1 is a nonzero at column index, multiplied by that entry and
// added to the row sum (Q17.30, saturating); row_last on it closes the row;
// cmd 2 closes the row as it stands; cmd 3 is dropped.
// Output channel (out_valid/out_stall): one item per closed row with row_sum,
// row_number (wraps at 2^20) and saturated.
// Throughput: one input item per cycle while in_stall is low, set by the
// one-access-per-cycle vector store and the single 16x16 multiplier.
// A closing item passes the store read into the s1 registers, the multiply
// into the queue and the accumulate into the output register.
// A four-entry queue sits between the multiply front and the accumulator.
// When the receiver stalls, the result holds; non-closing items keep
// draining, and in_stall rises once the queue fills behind a second result.
// Reset clears the row sum, row counter, flag and queue; the vector store is
// not cleared and must be written before use.
`default_nettype none
module csr_sparse_matvec_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [11:0]        index,
	input  wire logic signed [15:0] value,
	input  wire logic               row_last,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [47:0]      row_sum,
	output logic [19:0]             row_number,
	output logic                    saturated
);

	logic                  push;
	logic                  q_full;
	logic                  q_valid;
	logic                  pop;
	csm_pkg::queue_entry_t push_entry;
	csm_pkg::queue_entry_t head;

	csm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.row_last   (row_last),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	csm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.q_valid    (q_valid),
		.head       (head),
		.pop        (pop)
	);

	csm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_sum    (row_sum),
		.row_number (row_number),
		.saturated  (saturated)
	);

endmodule
`default_nettype wire

[tb/tb_csr_sparse_matvec_top.sv]
module tb_csr_sparse_matvec_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [11:0] FULL_COL = 12'd7;
	// long rows of full-scale products, large sums of both signs
	localparam int FULL_RUN = 100;
	localparam int LATENCY_PAD = 8;
	localparam int DRAIN_LIMIT = 20000;

	typedef struct {
		logic signed [47:0] sum;
		logic [19:0]        row;
		logic               sat;
	} row_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [11:0] index = '0;
	logic signed [15:0] value = '0;
	logic row_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [47:0] row_sum;
	logic [19:0] row_number;
	logic saturated;

	// predictor state
	logic signed [15:0] vec_shadow [0:csm_pkg::VECTOR_DEPTH-1];
	bit col_written [0:csm_pkg::VECTOR_DEPTH-1];
	logic [11:0] written_cols [$];
	logic signed [47:0] acc_shadow = '0;
	logic [19:0] row_shadow = '0;
	logic sat_shadow = 1'b0;
	row_result_t row_results_due [$];
	row_result_t got_row;

	int mismatches = 0;
	int items_sent = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold = 0;

	csr_sparse_matvec_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.index(index),
		.value(value),
		.row_last(row_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.row_sum(row_sum),
		.row_number(row_number),
		.saturated(saturated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#96000000;
		$display("tb_csr_sparse_matvec_top: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch @%0t: %s", $time, what);
	endtask

	function automatic void close_row_shadow();
		row_result_t r;
		r.sum = acc_shadow;
		r.row = row_shadow;
		r.sat = sat_shadow;
		row_results_due.push_back(r);
		acc_shadow = '0;
		sat_shadow = 1'b0;
		row_shadow = row_shadow + 20'd1;
	endfunction

	function automatic void predict_row(input logic [1:0] c, input logic [11:0] ix,
			input logic signed [15:0] v, input logic rl);
		logic signed [31:0] prod;
		logic signed [48:0] sum;
		case (c)
		csm_pkg::CMD_WRITE: begin
			vec_shadow[ix] = v;
			if (!col_written[ix]) begin
				col_written[ix] = 1'b1;
				written_cols.push_back(ix);
			end
		end
		csm_pkg::CMD_NZ: begin
			prod = v * vec_shadow[ix];
			sum = acc_shadow + prod;
			if (sum > csm_pkg::ACC_MAX) begin
				sum = csm_pkg::ACC_MAX;
				sat_shadow = 1'b1;
			end else if (sum < csm_pkg::ACC_MIN) begin
				sum = csm_pkg::ACC_MIN;
				sat_shadow = 1'b1;
			end
			acc_shadow = sum[47:0];
			if (rl)
				close_row_shadow();
		end
		csm_pkg::CMD_CLOSE: begin
			close_row_shadow();
		end
		default: begin
		end
		endcase
	endfunction

	// receiver: random stall, or a counted hold-off when rx_hold is loaded
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold <= rx_hold - 1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (row_results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected row result, row_number %0d",
					row_number));
			end else begin
				got_row = row_results_due.pop_front();
				if (row_sum !== got_row.sum)
					report_mismatch($sformatf("row %0d: row_sum %0d, want %0d",
						got_row.row, row_sum, got_row.sum));
				if (row_number !== got_row.row)
					report_mismatch($sformatf("row_number %0d, want %0d",
						row_number, got_row.row));
				if (saturated !== got_row.sat)
					report_mismatch($sformatf("row %0d: saturated %b, want %b",
						got_row.row, saturated, got_row.sat));
			end
		end
	end

	task automatic set_traffic(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	// offer one item at the falling edge, hold it until taken
	task automatic send_item(input logic [1:0] c, input logic [11:0] ix,
			input logic signed [15:0] v, input logic rl);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		index <= ix;
		value <= v;
		row_last <= rl;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predict_row(c, ix, v, rl);
		if (c != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic wait_rows_done();
		int n;
		@(negedge clk);
		in_valid <= 1'b0;
		for (n = 0; n < DRAIN_LIMIT && row_results_due.size() != 0; n++)
			@(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
		if (row_results_due.size() != 0) begin
			report_mismatch($sformatf("%0d row results never arrived",
				row_results_due.size()));
			row_results_due.delete();
		end
	endtask

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(9))
		0: return 16'sh8000;
		1: return 16'sh7fff;
		default: return 16'($urandom());
		endcase
	endfunction

	// only columns already written are read
	function automatic logic [11:0] pick_col();
		return written_cols[$urandom_range(written_cols.size() - 1)];
	endfunction

	task automatic send_row(input int len, input bit close_by_cmd);
		int k;
		for (k = 0; k < len; k++) begin
			if ($urandom_range(9) == 0)
				send_item(csm_pkg::CMD_WRITE, 12'($urandom_range(4095)), pick_value(),
					1'($urandom()));
			send_item(csm_pkg::CMD_NZ, pick_col(), pick_value(),
				!close_by_cmd && k == len - 1);
		end
		if (close_by_cmd)
			send_item(csm_pkg::CMD_CLOSE, 12'($urandom()), pick_value(), 1'($urandom()));
	endtask

	task automatic run_mix(input int n);
		int target;
		int r;
		int k;
		target = items_sent + n;
		while (items_sent < target) begin
			r = $urandom_range(99);
			if (r < 70) begin
				send_row($urandom_range(1, 8), $urandom_range(4) == 0);
			end else if (r < 85) begin
				send_item(csm_pkg::CMD_WRITE, 12'($urandom()), pick_value(),
					1'($urandom()));
			end else if (r < 92) begin
				send_item(csm_pkg::CMD_CLOSE, 12'($urandom()), pick_value(),
					1'($urandom()));
			end else if (r < 96) begin
				send_item(CMD_UNUSED, 12'($urandom()), pick_value(), 1'($urandom()));
			end else begin
				// open row left hanging; merges into whatever comes next
				for (k = 0; k < $urandom_range(1, 3); k++)
					send_item(csm_pkg::CMD_NZ, pick_col(), pick_value(), 1'b0);
			end
		end
	endtask

	task automatic test_directed();
		set_traffic(0, 0);
		send_item(csm_pkg::CMD_WRITE, 12'd0, 16'sh8000, 1'b0);
		send_item(csm_pkg::CMD_WRITE, 12'hfff, 16'sh7fff, 1'b1);
		send_item(csm_pkg::CMD_WRITE, 12'haaa, 16'sh5555, 1'b0);
		send_item(csm_pkg::CMD_WRITE, 12'h555, -16'sh5556, 1'b1);
		send_item(csm_pkg::CMD_WRITE, 12'd1, 16'sh0000, 1'b0);
		// empty row
		send_item(csm_pkg::CMD_CLOSE, 12'd0, 16'sh0000, 1'b0);
		send_item(csm_pkg::CMD_NZ, 12'd0, 16'sh8000, 1'b0);
		send_item(csm_pkg::CMD_NZ, 12'hfff, 16'sh7fff, 1'b0);
		send_item(csm_pkg::CMD_NZ, 12'haaa, -16'sh5556, 1'b1);
		send_item(csm_pkg::CMD_NZ, 12'd1, 16'sh7fff, 1'b1);
		// unused command mid-row, then close an open row with row_last set
		send_item(csm_pkg::CMD_NZ, 12'd0, 16'sh7fff, 1'b0);
		send_item(CMD_UNUSED, 12'hfff, 16'sh7fff, 1'b1);
		send_item(csm_pkg::CMD_CLOSE, 12'hfff, 16'shffff, 1'b1);
		send_item(csm_pkg::CMD_WRITE, 12'h555, 16'shffff, 1'b1);
		send_item(csm_pkg::CMD_NZ, 12'h555, 16'sh8000, 1'b1);
		send_item(csm_pkg::CMD_NZ, 12'h555, 16'sh0001, 1'b0);
		send_item(csm_pkg::CMD_NZ, 12'haaa, 16'sh5555, 1'b1);
		wait_rows_done();
	endtask

	task automatic test_full_scale();
		set_traffic(0, 0);
		send_item(csm_pkg::CMD_WRITE, FULL_COL, 16'sh8000, 1'b0);
		// long positive climb, then a long negative one
		repeat (FULL_RUN) send_item(csm_pkg::CMD_NZ, FULL_COL, 16'sh8000, 1'b0);
		send_item(csm_pkg::CMD_NZ, FULL_COL, 16'sh7fff, 1'b1);
		repeat (FULL_RUN) send_item(csm_pkg::CMD_NZ, FULL_COL, 16'sh7fff, 1'b0);
		send_item(csm_pkg::CMD_NZ, FULL_COL, 16'sh8000, 1'b1);
		send_item(csm_pkg::CMD_NZ, FULL_COL, 16'sh0001, 1'b1);
		wait_rows_done();
	endtask

	task automatic test_random_traffic();
		set_traffic(0, 0);
		run_mix(275);
		set_traffic(69, 0);
		run_mix(275);
		set_traffic(0, 69);
		run_mix(275);
		set_traffic(15, 15);
		run_mix(275);
		wait_rows_done();
	endtask

	task automatic test_backpressure();
		set_traffic(0, 0);
		rx_hold = 400;
		repeat (30) send_row($urandom_range(1, 3), $urandom_range(3) == 0);
		wait_rows_done();
		set_traffic(15, 15);
		repeat (20) send_row($urandom_range(1, 4), 1'b0);
		wait_rows_done();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_scale();
		test_random_traffic();
		test_backpressure();

		if (mismatches == 0)
			$display("tb_csr_sparse_matvec_top: PASS");
		else
			$display("tb_csr_sparse_matvec_top: FAIL");
		$finish;
	end

endmodule

[csr_sparse_matvec_top.f]
+incdir+src
src/csm_pkg.sv
src/csm_front.sv
src/csm_queue.sv
src/csm_back.sv
src/csr_sparse_matvec_top.sv
tb/tb_csr_sparse_matvec_top.sv
